// ----- sv/fcav_pkg.sv -----
// Shared types, constants and check functions for the frame check block.
// No dependencies; imported by fcav_core, fcav_out and the top level.
`default_nettype none

package fcav_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // configuration register indexes
   localparam logic [1:0] REG_CHECK_MODE = 2'd0;
   localparam logic [1:0] REG_DIRECTION  = 2'd1;

   // position of a result within one request's group
   localparam logic [1:0] IDX_ECHO   = 2'd0;
   localparam logic [1:0] IDX_CHECK0 = 2'd1;
   localparam logic [1:0] IDX_CHECK1 = 2'd2;

   typedef struct packed {
      logic       check_mode;
      logic       direction;
      logic       clear;       // direction write: drop the frame in progress
   } cfg_type;

   // everything needed to emit the results of one request
   typedef struct packed {
      logic [7:0] first_byte;  // echo byte, or zero for a verdict
      logic [7:0] check0;
      logic [7:0] check1;
      logic [1:0] last_idx;    // index of the final result in the group
      logic       ok;
   } bundle_type;

   // Modbus CRC-16, one byte, bitwise reflected update
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      r = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (r[0]) begin
            r = (r >> 1) ^ CRC_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

   // upper-case hex ASCII character of one nibble
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'h0, nib};
      return (nib < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
   endfunction

endpackage

`default_nettype wire

// ----- sv/frame_check_append_verify_top.sv -----
// Top level of the frame check block: configuration registers, check core, result queue.
// Depends on fcav_pkg, fcav_core and fcav_out.
//
// Frame bytes enter on req_ (one byte per request, req_tlast on the final byte) and one
// request is taken every cycle while the two-bundle result queue has room. Each request
// updates the Modbus CRC-16 and the byte sum; its results pass through the queue. In
// append direction a byte yields one echo result and the final byte yields three results
// (echo plus two check bytes), so a frame of N bytes needs N+2 results; the result port,
// one beat per cycle while rsp_tready is high, sets the sustained rate. In verify
// direction only the final byte yields a result: the pass/fail verdict on rsp_tuser[1].
// Configuration writes are always accepted; writing direction drops a frame in progress.
`default_nettype none

module frame_check_append_verify_top
   import fcav_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic       req_tlast,   // frame_end
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic [1:0]      rsp_tuser,   // [0] is_check_byte, [1] verify_ok
   output logic            rsp_tlast,   // run_last
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic       csr_data
);

   logic       mode_ff;
   logic       dir_ff;
   logic       csr_fire;
   logic       req_fire;
   logic       space;
   logic       push;
   cfg_type    cfg;
   bundle_type bundle;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_tready = space;
   assign req_fire  = req_tvalid && req_tready;

   always_comb begin
      cfg.check_mode = mode_ff;
      cfg.direction  = dir_ff;
      cfg.clear      = csr_fire && (csr_index == REG_DIRECTION);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         dir_ff  <= 1'b0;
      end else if (csr_fire) begin
         unique case (csr_index)
            REG_CHECK_MODE: mode_ff <= csr_data;
            REG_DIRECTION:  dir_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   fcav_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .fire      (req_fire),
      .data_byte (req_tdata),
      .frame_end (req_tlast),
      .push      (push),
      .bundle    (bundle)
   );

   fcav_out u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .bundle     (bundle),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ----- sv/fcav_core.sv -----
// Frame check state: CRC and byte sum kept in parallel, trailer hold, verdict.
// Depends on fcav_pkg; produces one result bundle per request that yields results.
`default_nettype none

module fcav_core
   import fcav_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       fire,
   input  wire logic [7:0] data_byte,
   input  wire logic       frame_end,
   output logic            push,
   output bundle_type      bundle
);

   logic [15:0] crc_ff, crc_in;
   logic [7:0]  sum_ff, sum_in;
   logic [1:0]  seen_ff, seen_in;
   logic [15:0] held_ff, held_in;

   logic [7:0]  absorb_byte;
   logic        absorb_en;
   logic        first;
   logic [15:0] crc_new;
   logic [7:0]  sum_new;
   logic [7:0]  c0;
   logic [7:0]  c1;

   always_comb begin
      // verify checks each byte only once two newer bytes have arrived
      absorb_byte = cfg.direction ? held_ff[15:8] : data_byte;
      absorb_en   = !cfg.direction || (seen_ff >= 2'd2);
      first       = cfg.direction ? (seen_ff == 2'd2) : (seen_ff == 2'd0);
      crc_new     = absorb_en ? crc_update(crc_ff, absorb_byte) : crc_ff;
      sum_new     = (absorb_en && !first) ? (sum_ff + absorb_byte) : sum_ff;
      held_in     = cfg.direction ? {held_ff[7:0], data_byte} : held_ff;
      seen_in     = (seen_ff == 2'd3) ? seen_ff : (seen_ff + 2'd1);
      crc_in      = crc_new;
      sum_in      = sum_new;

      if (cfg.check_mode) begin
         c0 = hex_char(sum_new[7:4]);
         c1 = hex_char(sum_new[3:0]);
      end else begin
         c0 = crc_new[7:0];
         c1 = crc_new[15:8];
      end

      push              = fire && (!cfg.direction || frame_end);
      bundle.check0     = c0;
      bundle.check1     = c1;
      if (cfg.direction) begin
         bundle.first_byte = 8'h00;
         bundle.last_idx   = IDX_ECHO;
         bundle.ok         = (seen_ff != 2'd0) && (held_in[15:8] == c0)
                             && (held_in[7:0] == c1);
      end else begin
         bundle.first_byte = data_byte;
         bundle.last_idx   = frame_end ? IDX_CHECK1 : IDX_ECHO;
         bundle.ok         = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg.clear || (fire && frame_end)) begin
         crc_ff  <= CRC_INIT;
         sum_ff  <= 8'h00;
         seen_ff <= 2'd0;
         held_ff <= 16'h0000;
      end else if (fire) begin
         crc_ff  <= crc_in;
         sum_ff  <= sum_in;
         seen_ff <= seen_in;
         held_ff <= held_in;
      end
   end

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && frame_end) |=> (seen_ff == 2'd0 && crc_ff == CRC_INIT))
      else $error("frame state not cleared after frame end");

   a_append_no_hold: assert property (@(posedge clock) disable iff (reset)
      (fire && !cfg.direction && !cfg.clear && held_ff == 16'h0000) |=> (held_ff == 16'h0000))
      else $error("trailer hold changed in append direction");

   a_push_group: assert property (@(posedge clock) disable iff (reset)
      push |-> (bundle.last_idx == IDX_ECHO || (bundle.last_idx == IDX_CHECK1 && !cfg.direction)))
      else $error("bad result group size");

endmodule

`default_nettype wire

// ----- sv/fcav_out.sv -----
// Result queue: two bundles deep, each expanded into one or three result beats.
// Depends on fcav_pkg; decouples request acceptance from result backpressure.
`default_nettype none

module fcav_out
   import fcav_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire bundle_type bundle,
   output logic            space,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic [1:0]      rsp_tuser,   // [0] is_check_byte, [1] verify_ok
   output logic            rsp_tlast    // run_last
);

   bundle_type slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic [1:0] idx_ff;

   bundle_type head;
   logic       pop;
   logic       beat;

   always_comb begin
      head       = slot_ff[rd_ptr_ff];
      rsp_tvalid = (count_ff != 2'd0);
      beat       = rsp_tvalid && rsp_tready;
      pop        = beat && (idx_ff == head.last_idx);
      space      = (count_ff != 2'd2);
      count_in   = count_ff + {1'b0, push} - {1'b0, pop};

      unique case (idx_ff)
         IDX_CHECK0: begin
            rsp_tdata    = head.check0;
            rsp_tuser[0] = 1'b1;
         end
         IDX_CHECK1: begin
            rsp_tdata    = head.check1;
            rsp_tuser[0] = 1'b1;
         end
         default: begin
            rsp_tdata    = head.first_byte;
            rsp_tuser[0] = 1'b0;
         end
      endcase
      rsp_tuser[1] = head.ok;
      rsp_tlast    = (idx_ff == head.last_idx);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         idx_ff    <= IDX_ECHO;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
            idx_ff    <= IDX_ECHO;
         end else if (beat) begin
            idx_ff    <= idx_ff + 2'd1;
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != 2'd2))
      else $error("result queue overflow");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (idx_ff <= head.last_idx))
      else $error("result index past end of group");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 && push) |=> rsp_tvalid)
      else $error("queued results not presented");

endmodule

`default_nettype wire
